// File: src/iatp_pkg.sv
// Shared types and constants for the IP address text parser.
`timescale 1ns / 1ps
`default_nettype none
package iatp_pkg;

  // Character codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [3:0] HEX_LETTER_BIAS = 4'd9;

  localparam int MIN_TEXT_LEN = 2;

  // Range and saturation limits
  localparam logic [8:0]  QUAD_MAX      = 9'd255;
  localparam logic [8:0]  QUAD_SAT      = 9'd256;
  localparam logic [1:0]  LAST_QUAD     = 2'd3;
  localparam logic [16:0] WORD_MAX      = 17'h0ffff;
  localparam logic [16:0] WORD_SAT      = 17'h10000;
  localparam logic [4:0]  V6_BYTES      = 5'd16;
  localparam logic [7:0]  PREFIX_SAT    = 8'd129;
  localparam logic [7:0]  V6_PREFIX_MAX = 8'd128;
  localparam logic [7:0]  V4_PREFIX_MAX = 8'd32;

  // One classified character
  typedef struct packed {
    logic       last;
    logic       len_ok;   // meaningful on the last character only
    logic       is_dec;
    logic       is_hex;
    logic [3:0] nib;      // digit value, decimal or hex
    logic       is_dot;
    logic       is_colon;
    logic       is_slash;
  } iatp_item_t;

  // One result transaction
  typedef struct packed {
    logic        valid_res;
    logic        is_v6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_len;
  } iatp_result_t;

endpackage
`default_nettype wire

// File: src/ip_address_text_parser.sv
// Top level of the streaming IPv4 / IPv6 address text parser.
//
// Feed the address text one character per transaction with push/full, and
// raise last on the final character; each string yields exactly one result
// transaction on the empty/pop side. A result carries valid_res, is_v6, the
// 128-bit address split into address_high and address_low (IPv4 sits in bits
// 31..0 of address_low) and prefix_len, which is the '/n' value or the family
// default of 32 or 128. An invalid string reports all result fields as zero.
// Strings shorter than two characters or longer than MAX_TEXT_LEN are
// rejected. The block takes one character every clock cycle, sustained, as
// long as results are popped; that figure is set by the per-character parser
// update in the back end, an accumulate-and-flag step. The result for a
// string passes from the character queue into the parser, then through the
// result assembly register and the result queue to the output ports. The
// character queue and the result queue are each two transactions deep, so
// either side may stall without blocking the other until its queue fills.
`timescale 1ns / 1ps
`default_nettype none
module ip_address_text_parser #(
  parameter int MAX_TEXT_LEN = 43
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  ch,
  input  wire logic        last,
  output logic             empty,
  input  wire logic        pop,
  output logic             valid_res,
  output logic             is_v6,
  output logic [63:0]      address_high,
  output logic [63:0]      address_low,
  output logic [7:0]       prefix_len
);
  import iatp_pkg::*;

  localparam int QueueDepth = 2;
  localparam int ItemW      = $bits(iatp_item_t);
  localparam int ResultW    = $bits(iatp_result_t);

  // Front end to character queue
  logic               cq_wr;
  iatp_item_t         cq_wr_item;
  logic               cq_full;
  logic [ItemW-1:0]   cq_rd_data;
  logic               cq_empty;
  logic               cq_rd;
  iatp_item_t         cq_rd_item;

  // Back end to result queue
  logic               rq_wr;
  iatp_result_t       rq_wr_res;
  logic               rq_full;
  logic [ResultW-1:0] rq_rd_data;
  iatp_result_t       rq_rd_res;

  iatp_front #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .ch     (ch),
    .last   (last),
    .q_wr   (cq_wr),
    .q_item (cq_wr_item),
    .q_full (cq_full)
  );

  iatp_queue #(
    .W     (ItemW),
    .DEPTH (QueueDepth)
  ) u_char_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cq_wr),
    .wr_data (ItemW'(cq_wr_item)),
    .full    (cq_full),
    .rd_en   (cq_rd),
    .rd_data (cq_rd_data),
    .empty   (cq_empty)
  );

  assign cq_rd_item = iatp_item_t'(cq_rd_data);

  iatp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_empty (cq_empty),
    .in_item  (cq_rd_item),
    .in_pop   (cq_rd),
    .out_full (rq_full),
    .out_wr   (rq_wr),
    .out_data (rq_wr_res)
  );

  iatp_queue #(
    .W     (ResultW),
    .DEPTH (QueueDepth)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rq_wr),
    .wr_data (ResultW'(rq_wr_res)),
    .full    (rq_full),
    .rd_en   (pop),
    .rd_data (rq_rd_data),
    .empty   (empty)
  );

  assign rq_rd_res    = iatp_result_t'(rq_rd_data);
  assign valid_res    = rq_rd_res.valid_res;
  assign is_v6        = rq_rd_res.is_v6;
  assign address_high = rq_rd_res.address_high;
  assign address_low  = rq_rd_res.address_low;
  assign prefix_len   = rq_rd_res.prefix_len;

endmodule
`default_nettype wire

// File: src/iatp_queue.sv
// Small first-word-fall-through queue built from registers.
`timescale 1ns / 1ps
`default_nettype none
module iatp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: src/iatp_front.sv
// Front end: accept characters, classify them and track the string length.
`timescale 1ns / 1ps
`default_nettype none
module iatp_front #(
  parameter int MAX_TEXT_LEN = 43
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        ch,
  input  wire logic              last,
  output logic                   q_wr,
  output iatp_pkg::iatp_item_t   q_item,
  input  wire logic              q_full
);
  import iatp_pkg::*;

  localparam int CW = $clog2(MAX_TEXT_LEN + 1);

  logic [CW-1:0] char_count;
  logic [CW-1:0] char_count_next;
  logic          too_long;
  logic          too_long_next;
  logic          is_dec;
  logic          is_lower;
  logic          is_upper;

  assign full = q_full;
  assign q_wr = push && !q_full;

  assign is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_lower = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_F);
  assign is_upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_F);

  // Count stops at the limit; one more character marks the string too long.
  always_comb begin
    char_count_next = char_count;
    too_long_next   = too_long;
    if (char_count >= CW'(MAX_TEXT_LEN)) begin
      too_long_next = 1'b1;
    end else begin
      char_count_next = char_count + 1'b1;
    end
  end

  always_comb begin
    q_item          = '0;
    q_item.last     = last;
    q_item.len_ok   = !too_long_next && (char_count_next >= CW'(MIN_TEXT_LEN));
    q_item.is_dec   = is_dec;
    q_item.is_hex   = is_dec || is_lower || is_upper;
    q_item.nib      = is_dec ? ch[3:0] : ch[3:0] + HEX_LETTER_BIAS;
    q_item.is_dot   = (ch == CH_DOT);
    q_item.is_colon = (ch == CH_COLON);
    q_item.is_slash = (ch == CH_SLASH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      too_long   <= 1'b0;
    end else if (q_wr) begin
      if (last) begin
        char_count <= '0;
        too_long   <= 1'b0;
      end else begin
        char_count <= char_count_next;
        too_long   <= too_long_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/iatp_back.sv
// Back end: run the IPv4, IPv6 and prefix parsers and assemble the result.
`timescale 1ns / 1ps
`default_nettype none
module iatp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_empty,
  input  wire iatp_pkg::iatp_item_t in_item,
  output logic                    in_pop,
  input  wire logic               out_full,
  output logic                    out_wr,
  output iatp_pkg::iatp_result_t  out_data
);
  import iatp_pkg::*;

  typedef struct packed {
    logic             ok;
    logic             v6;
    logic [7:0]       plen;
    logic [31:0]      v4;
    logic [7:0][15:0] head;
    logic [7:0][15:0] tail;
    logic [3:0]       tw;
  } fin_t;

  // Parser state
  logic             in_prefix, in_prefix_next;
  logic [1:0]       qidx, qidx_next;
  logic [8:0]       qval, qval_next;
  logic             qseen, qseen_next;
  logic             qfail, qfail_next;
  logic [31:0]      qaddr, qaddr_next;
  logic [7:0][15:0] head, head_next;
  logic [7:0][15:0] tail, tail_next;
  logic [4:0]       hbt, hbt_next;
  logic [4:0]       tbt, tbt_next;
  logic             gap, gap_next;
  logic [16:0]      hval, hval_next;
  logic             hseen, hseen_next;
  logic             cpend, cpend_next;
  logic             hfail, hfail_next;
  logic [7:0]       pval, pval_next;
  logic             pseen, pseen_next;
  logic             pfail, pfail_next;

  // Word store port
  logic             wr_en;
  logic             wr_tail;
  logic [2:0]       wr_idx;
  logic [15:0]      wr_val;

  logic [11:0]      q_acc;
  logic [10:0]      p_acc;
  logic [20:0]      h_acc;

  fin_t             fin;
  fin_t             fin_next;
  logic             fin_valid;
  logic             fin_ready;
  logic             do_feed;
  logic             do_finish;

  assign fin_ready = !fin_valid || !out_full;
  assign in_pop    = !in_empty && (!in_item.last || fin_ready);
  assign out_wr    = fin_valid && !out_full;
  assign do_feed   = !in_prefix && !in_item.is_slash;
  assign do_finish = !in_prefix && (in_item.is_slash || in_item.last);

  assign q_acc = ({3'b0, qval} << 3) + ({3'b0, qval} << 1) + {8'b0, in_item.nib};
  assign p_acc = ({3'b0, pval} << 3) + ({3'b0, pval} << 1) + {7'b0, in_item.nib};
  assign h_acc = {hval, in_item.nib};

  // Per-character update, then the end-of-part checks on the updated state.
  always_comb begin
    in_prefix_next = in_prefix;
    qidx_next      = qidx;
    qval_next      = qval;
    qseen_next     = qseen;
    qfail_next     = qfail;
    qaddr_next     = qaddr;
    hbt_next       = hbt;
    tbt_next       = tbt;
    gap_next       = gap;
    hval_next      = hval;
    hseen_next     = hseen;
    cpend_next     = cpend;
    hfail_next     = hfail;
    pval_next      = pval;
    pseen_next     = pseen;
    pfail_next     = pfail;
    wr_en          = 1'b0;
    wr_tail        = 1'b0;
    wr_idx         = '0;
    wr_val         = '0;

    if (in_prefix) begin
      if (!pfail) begin
        if (in_item.is_dec) begin
          pval_next  = (p_acc > 11'(PREFIX_SAT)) ? PREFIX_SAT : p_acc[7:0];
          pseen_next = 1'b1;
        end else begin
          pfail_next = 1'b1;
        end
      end
    end else if (in_item.is_slash) begin
      in_prefix_next = 1'b1;
    end

    if (do_feed) begin
      // Dotted quad
      if (!qfail) begin
        if (in_item.is_dec) begin
          qval_next  = (q_acc > 12'(QUAD_SAT)) ? QUAD_SAT : q_acc[8:0];
          qseen_next = 1'b1;
        end else if (in_item.is_dot) begin
          if (!qseen || qidx == LAST_QUAD || qval > QUAD_MAX) begin
            qfail_next = 1'b1;
          end else begin
            qaddr_next = {qaddr[23:0], qval[7:0]};
            qidx_next  = qidx + 1'b1;
            qval_next  = '0;
            qseen_next = 1'b0;
          end
        end else begin
          qfail_next = 1'b1;
        end
      end

      // Hex words
      if (!hfail) begin
        if (cpend && in_item.is_colon) begin
          cpend_next = 1'b0;
          if (gap) begin
            hfail_next = 1'b1;
          end else begin
            gap_next   = 1'b1;
            hseen_next = 1'b0;
          end
        end else if (cpend && !hseen) begin
          cpend_next = 1'b0;
          hfail_next = 1'b1;
        end else if (hseen && !cpend) begin
          if (in_item.is_hex) begin
            hval_next = (h_acc > 21'(WORD_SAT)) ? WORD_SAT : h_acc[16:0];
          end else if (in_item.is_colon) begin
            if (hval > WORD_MAX || hbt >= V6_BYTES) begin
              hfail_next = 1'b1;
            end else begin
              wr_en      = 1'b1;
              wr_tail    = gap;
              wr_idx     = gap ? tbt[3:1] : hbt[3:1];
              wr_val     = hval[15:0];
              tbt_next   = gap ? tbt + 5'd2 : tbt;
              hbt_next   = hbt + 5'd2;
              hval_next  = '0;
              cpend_next = 1'b1;
            end
          end else begin
            hfail_next = 1'b1;
          end
        end else begin
          // No word open: either nothing before, or a single colon just closed one.
          cpend_next = 1'b0;
          hseen_next = 1'b0;
          if (in_item.is_hex) begin
            hval_next  = {13'b0, in_item.nib};
            hseen_next = 1'b1;
          end else if (in_item.is_colon && !gap) begin
            cpend_next = 1'b1;
          end else begin
            hfail_next = 1'b1;
          end
        end
      end
    end

    if (do_finish) begin
      if (!qfail_next) begin
        if (qidx_next != LAST_QUAD || !qseen_next || qval_next > QUAD_MAX) begin
          qfail_next = 1'b1;
        end else begin
          qaddr_next = {qaddr_next[23:0], qval_next[7:0]};
        end
      end
      if (!hfail_next) begin
        if (cpend_next) begin
          if (!hseen_next) begin
            hfail_next = 1'b1;
          end
        end else if (hseen_next) begin
          if (hval_next > WORD_MAX || hbt_next >= V6_BYTES) begin
            hfail_next = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_tail   = gap_next;
            wr_idx    = gap_next ? tbt_next[3:1] : hbt_next[3:1];
            wr_val    = hval_next[15:0];
            tbt_next  = gap_next ? tbt_next + 5'd2 : tbt_next;
            hbt_next  = hbt_next + 5'd2;
            hval_next = '0;
          end
        end
      end
    end
  end

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (wr_en && !wr_tail) begin
      head_next[wr_idx] = wr_val;
    end
    if (wr_en && wr_tail) begin
      tail_next[wr_idx] = wr_val;
    end
  end

  // Verdict for the string, taken on its last character
  always_comb begin
    fin_next      = '0;
    fin_next.ok   = in_item.len_ok;
    fin_next.v4   = qaddr_next;
    fin_next.head = head_next;
    fin_next.tail = tail_next;
    fin_next.tw   = tbt_next[4:1];
    if (in_prefix_next && (pfail_next || !pseen_next || pval_next > V6_PREFIX_MAX)) begin
      fin_next.ok = 1'b0;
    end
    if (fin_next.ok) begin
      if (!qfail_next) begin
        fin_next.plen = in_prefix_next ? pval_next : V4_PREFIX_MAX;
        if (fin_next.plen > V4_PREFIX_MAX) begin
          fin_next.ok = 1'b0;
        end
      end else if (!hfail_next) begin
        fin_next.v6   = 1'b1;
        fin_next.plen = in_prefix_next ? pval_next : V6_PREFIX_MAX;
      end else begin
        fin_next.ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_prefix <= 1'b0;
      qidx      <= '0;
      qval      <= '0;
      qseen     <= 1'b0;
      qfail     <= 1'b0;
      qaddr     <= '0;
      head      <= '0;
      tail      <= '0;
      hbt       <= '0;
      tbt       <= '0;
      gap       <= 1'b0;
      hval      <= '0;
      hseen     <= 1'b0;
      cpend     <= 1'b0;
      hfail     <= 1'b0;
      pval      <= '0;
      pseen     <= 1'b0;
      pfail     <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      if (in_pop && in_item.last) begin
        // Hand the verdict on and clear for the next string.
        fin_valid <= 1'b1;
        in_prefix <= 1'b0;
        qidx      <= '0;
        qval      <= '0;
        qseen     <= 1'b0;
        qfail     <= 1'b0;
        qaddr     <= '0;
        head      <= '0;
        tail      <= '0;
        hbt       <= '0;
        tbt       <= '0;
        gap       <= 1'b0;
        hval      <= '0;
        hseen     <= 1'b0;
        cpend     <= 1'b0;
        hfail     <= 1'b0;
        pval      <= '0;
        pseen     <= 1'b0;
        pfail     <= 1'b0;
      end else begin
        if (out_wr) begin
          fin_valid <= 1'b0;
        end
        if (in_pop) begin
          in_prefix <= in_prefix_next;
          qidx      <= qidx_next;
          qval      <= qval_next;
          qseen     <= qseen_next;
          qfail     <= qfail_next;
          qaddr     <= qaddr_next;
          head      <= head_next;
          tail      <= tail_next;
          hbt       <= hbt_next;
          tbt       <= tbt_next;
          gap       <= gap_next;
          hval      <= hval_next;
          hseen     <= hseen_next;
          cpend     <= cpend_next;
          hfail     <= hfail_next;
          pval      <= pval_next;
          pseen     <= pseen_next;
          pfail     <= pfail_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop && in_item.last) begin
      fin <= fin_next;
    end
  end

  // Place the words after the gap at the end of the address.
  always_comb begin
    logic [127:0] addr;
    logic [15:0]  word;
    logic [3:0]   sel;
    addr     = '0;
    out_data = '0;
    for (int j = 0; j < 8; j++) begin
      sel  = 4'(j) + fin.tw - 4'd8;
      word = fin.head[j];
      if ((5'(j) + {1'b0, fin.tw}) >= 5'd8) begin
        word = fin.tail[sel[2:0]];
      end
      addr[127 - 16 * j -: 16] = word;
    end
    if (fin.ok) begin
      out_data.valid_res  = 1'b1;
      out_data.is_v6      = fin.v6;
      out_data.prefix_len = fin.plen;
      if (fin.v6) begin
        out_data.address_high = addr[127:64];
        out_data.address_low  = addr[63:0];
      end else begin
        out_data.address_low  = {32'b0, fin.v4};
      end
    end
  end

endmodule
`default_nettype wire

// File: src/iatp_checker.sv
// Port-level checks for the address text parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module iatp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        valid_res,
  input wire logic        is_v6,
  input wire logic [63:0] address_high,
  input wire logic [63:0] address_low,
  input wire logic [7:0]  prefix_len
);

  // Reset drains both queues.
  a_reset_drains: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A rejected string reports all zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !valid_res |->
      !is_v6 && address_high == 64'd0 && address_low == 64'd0 && prefix_len == 8'd0)
    else $error("invalid result carries nonzero fields");

  // IPv4 results use only the low 32 bits and a prefix of at most 32.
  a_v4_shape: assert property (@(posedge clk) disable iff (rst)
    !empty && valid_res && !is_v6 |->
      address_high == 64'd0 && address_low[63:32] == 32'd0 && prefix_len <= 8'd32)
    else $error("malformed IPv4 result");

  // IPv6 prefixes never exceed 128.
  a_v6_prefix: assert property (@(posedge clk) disable iff (rst)
    !empty && valid_res && is_v6 |-> prefix_len <= 8'd128)
    else $error("IPv6 prefix out of range");

  // A waiting result holds until popped.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(valid_res) && $stable(is_v6) &&
      $stable(address_high) && $stable(address_low) && $stable(prefix_len))
    else $error("waiting result changed");

endmodule

bind ip_address_text_parser iatp_checker u_checker (.*);
`default_nettype wire

// File: tb/tb_ip_address_text_parser.sv
// Self-checking testbench for the IPv4 / IPv6 address text parser.
`timescale 1ns / 1ps
`default_nettype none
module tb_ip_address_text_parser;
  import iatp_pkg::*;

  localparam int TEXT_MAX    = 43;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_TICKS = 9;
  localparam int LONG_HOLD   = 300;     // receiver hold-off, long enough to back up the input
  localparam int RANDOM_CHARS = 1280;
  localparam int SETTLE_TICKS = 20;

  // One character transaction waiting to be offered, with its own lead-in gap.
  // A drain-marked character is held back until every string before it has
  // produced its result.
  typedef struct {
    logic [7:0] code;
    logic       fin;
    int         gap;
    bit         drain;
  } char_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  ch = 8'd0;
  logic        last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        valid_res;
  logic        is_v6;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [7:0]  prefix_len;

  ip_address_text_parser #(
    .MAX_TEXT_LEN(TEXT_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .ch(ch),
    .last(last),
    .empty(empty),
    .pop(pop),
    .valid_res(valid_res),
    .is_v6(is_v6),
    .address_high(address_high),
    .address_low(address_low),
    .prefix_len(prefix_len)
  );

  // Stimulus and scoreboard storage
  char_item_t   chars_to_send[$];
  iatp_result_t parsed_due[$];
  logic [7:0]   txt_buf[$];
  int           fault_count = 0;
  int           results_seen = 0;
  bit           char_taken = 1'b0;
  bit           res_taken = 1'b0;

  // Sender / receiver pacing state
  bit on_bus = 1'b0;
  bit gap_armed = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // ---------------------------------------------------------------------------
  // Parser shadow state: a single copy, reused by the predictor for each string in turn.
  // ---------------------------------------------------------------------------
  int unsigned txt_len;
  bit          overlong;
  bit          after_slash;
  // dotted-quad side
  int unsigned quad_idx;
  int unsigned quad_acc;
  bit          quad_dig;
  bit          quad_bad;
  logic [31:0] quad_addr;
  // hex-word side; words before the gap land in lead_b, after it in trail_b
  logic [7:0]  lead_b [16];
  logic [7:0]  trail_b [16];
  int unsigned v6_total;
  int unsigned trail_total;
  bit          dbl_colon;
  int unsigned word_acc;
  bit          word_dig;
  bit          colon_wait;
  bit          v6_bad;
  // prefix length after the first slash
  int unsigned pfx_acc;
  bit          pfx_dig;
  bit          pfx_bad;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  task clear_parse();
    txt_len = 0;
    overlong = 1'b0;
    after_slash = 1'b0;
    quad_idx = 0;
    quad_acc = 0;
    quad_dig = 1'b0;
    quad_bad = 1'b0;
    quad_addr = '0;
    foreach (lead_b[i]) begin
      lead_b[i] = '0;
      trail_b[i] = '0;
    end
    v6_total = 0;
    trail_total = 0;
    dbl_colon = 1'b0;
    word_acc = 0;
    word_dig = 1'b0;
    colon_wait = 1'b0;
    v6_bad = 1'b0;
    pfx_acc = 0;
    pfx_dig = 1'b0;
    pfx_bad = 1'b0;
  endtask

  function automatic bit is_decimal(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Hex digit value, or -1 for anything else.
  function automatic int hex_digit(logic [7:0] c);
    if (is_decimal(c)) return c - CH_ZERO;
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return c - CH_LOWER_A + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return c - CH_UPPER_A + 10;
    return -1;
  endfunction

  // Advance the dotted-quad reading by one character. Fields saturate one
  // above the byte limit so an oversize field fails at its dot or at the end.
  task quad_feed(input logic [7:0] c);
    if (quad_bad) return;
    if (is_decimal(c)) begin
      quad_acc = quad_acc * 10 + (c - CH_ZERO);
      if (quad_acc > QUAD_SAT) quad_acc = QUAD_SAT;
      quad_dig = 1'b1;
    end else if (c == CH_DOT) begin
      if (!quad_dig || quad_idx >= LAST_QUAD || quad_acc > QUAD_MAX) begin
        quad_bad = 1'b1;
      end else begin
        quad_addr = {quad_addr[23:0], 8'(quad_acc)};
        quad_idx++;
        quad_acc = 0;
        quad_dig = 1'b0;
      end
    end else begin
      quad_bad = 1'b1;
    end
  endtask

  task quad_close();
    if (quad_bad) return;
    if (quad_idx != LAST_QUAD || !quad_dig || quad_acc > QUAD_MAX) quad_bad = 1'b1;
    else quad_addr = {quad_addr[23:0], 8'(quad_acc)};
  endtask

  // Commit the current hex word as two bytes, on the head or tail side of
  // the gap depending on whether the double colon was seen.
  task word_store();
    if (word_acc > WORD_MAX || v6_total >= V6_BYTES) begin
      v6_bad = 1'b1;
      return;
    end
    if (!dbl_colon) begin
      lead_b[v6_total]     = word_acc[15:8];
      lead_b[v6_total + 1] = word_acc[7:0];
    end else begin
      trail_b[trail_total]     = word_acc[15:8];
      trail_b[trail_total + 1] = word_acc[7:0];
      trail_total += 2;
    end
    v6_total += 2;
    word_acc = 0;
  endtask

  // Advance the hex-word reading. A colon is held pending for one character
  // so that a following colon can be taken as the gap.
  task hex_feed(input logic [7:0] c);
    int h;
    if (v6_bad) return;
    h = hex_digit(c);
    if (colon_wait) begin
      colon_wait = 1'b0;
      if (c == CH_COLON) begin
        if (dbl_colon) begin
          v6_bad = 1'b1;
        end else begin
          dbl_colon = 1'b1;
          word_dig = 1'b0;
        end
        return;
      end
      if (!word_dig) begin
        v6_bad = 1'b1;
        return;
      end
      word_dig = 1'b0;
    end
    if (word_dig) begin
      if (h >= 0) begin
        word_acc = (word_acc << 4) | h;
        if (word_acc > WORD_SAT) word_acc = WORD_SAT;
      end else if (c == CH_COLON) begin
        word_store();
        if (!v6_bad) colon_wait = 1'b1;
      end else begin
        v6_bad = 1'b1;
      end
    end else begin
      if (h >= 0) begin
        word_acc = h;
        word_dig = 1'b1;
      end else if (c == CH_COLON && !dbl_colon) begin
        colon_wait = 1'b1;
      end else begin
        v6_bad = 1'b1;
      end
    end
  endtask

  task hex_close();
    if (v6_bad) return;
    if (colon_wait) begin
      if (!word_dig) v6_bad = 1'b1;
      return;
    end
    if (word_dig) word_store();
  endtask

  task pfx_feed(input logic [7:0] c);
    if (pfx_bad) return;
    if (is_decimal(c)) begin
      pfx_acc = pfx_acc * 10 + (c - CH_ZERO);
      if (pfx_acc > PREFIX_SAT) pfx_acc = PREFIX_SAT;
      pfx_dig = 1'b1;
    end else begin
      pfx_bad = 1'b1;
    end
  endtask

  // Feed one accepted character; on the final one, build the expected
  // result and start over for the next string.
  task parse_char(input logic [7:0] c, input logic fin, output bit produced,
                  output iatp_result_t res);
    bit          ok;
    int unsigned plen;
    int unsigned off;
    int          k;
    logic [7:0]  merged [16];
    produced = 1'b0;
    res = '0;
    plen = 0;
    if (txt_len >= TEXT_MAX) overlong = 1'b1;
    else txt_len++;
    if (after_slash) begin
      pfx_feed(c);
    end else if (c == CH_SLASH) begin
      quad_close();
      hex_close();
      after_slash = 1'b1;
    end else begin
      quad_feed(c);
      hex_feed(c);
      if (fin) begin
        quad_close();
        hex_close();
      end
    end
    if (!fin) return;
    produced = 1'b1;
    ok = !overlong && txt_len >= MIN_TEXT_LEN;
    if (after_slash && (pfx_bad || !pfx_dig || pfx_acc > V6_PREFIX_MAX)) ok = 1'b0;
    if (ok) begin
      // IPv4 wins whenever it parsed; an IPv4 prefix over 32 is not retried as IPv6
      if (!quad_bad) begin
        plen = after_slash ? pfx_acc : V4_PREFIX_MAX;
        if (plen > V4_PREFIX_MAX) ok = 1'b0;
        res.address_low = {32'd0, quad_addr};
      end else if (!v6_bad) begin
        res.is_v6 = 1'b1;
        plen = after_slash ? pfx_acc : V6_PREFIX_MAX;
        merged = lead_b;
        // right-align the words after the gap; the middle stays zero
        off = V6_BYTES - trail_total;
        for (k = 0; k < trail_total; k++) merged[(off + k) % 16] = trail_b[k];
        for (k = 0; k < 8; k++) begin
          res.address_high = {res.address_high[55:0], merged[k]};
          res.address_low  = {res.address_low[55:0], merged[k + 8]};
        end
      end else begin
        ok = 1'b0;
      end
    end
    if (ok) begin
      res.valid_res = 1'b1;
      res.prefix_len = 8'(plen);
    end else begin
      res = '0;
    end
    clear_parse();
  endtask

  // ---------------------------------------------------------------------------
  // Text generation: build one string in txt_buf, then queue it as transactions.
  // ---------------------------------------------------------------------------
  task put_str(input string s);
    for (int i = 0; i < s.len(); i++) txt_buf.push_back(s[i]);
  endtask

  task put_hex_digit(input int d);
    if (d < 10) txt_buf.push_back(8'(CH_ZERO + d));
    else if ($urandom_range(0, 1)) txt_buf.push_back(8'(CH_UPPER_A + d - 10));
    else txt_buf.push_back(8'(CH_LOWER_A + d - 10));
  endtask

  // Mostly one to four digits; now and then five, which usually overflows.
  task put_hex_word();
    int nd;
    nd = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
    repeat (nd) put_hex_digit($urandom_range(0, 15));
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0: return CH_COLON;
      1: return CH_DOT;
      2: return CH_SLASH;
      3: return 8'(CH_ZERO + $urandom_range(0, 9));
      4: return 8'(CH_LOWER_A + $urandom_range(0, 6));   // one past 'f' on purpose
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic string dec_field();
    case ($urandom_range(0, 9))
      0: return $sformatf("%0d", $urandom_range(256, 99999));
      1: return $sformatf("%03d", $urandom_range(0, 255));
      default: return $sformatf("%0d", $urandom_range(0, 255));
    endcase
  endfunction

  // Optional prefix: up to hi, up to hi + 20 or up to 2000, or just a slash
  // or leading zeros; often no prefix at all.
  task maybe_prefix(input int hi);
    case ($urandom_range(0, 6))
      3: put_str($sformatf("/%0d", $urandom_range(0, hi)));
      4: put_str($sformatf("/%0d", $urandom_range(0, hi + 20)));
      5: put_str($sformatf("/%0d", $urandom_range(0, 2000)));
      6: put_str($urandom_range(0, 1) ? "/" : $sformatf("/00%0d", $urandom_range(0, 40)));
      default: ;
    endcase
  endtask

  task gen_quad_text();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 4;
    for (int i = 0; i < n; i++) begin
      if (i > 0) txt_buf.push_back(CH_DOT);
      if ($urandom_range(0, 29) != 0) put_str(dec_field());
    end
    maybe_prefix(40);
  endtask

  task gen_v6_text();
    int nw;
    int gap_at;
    nw = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 8);
    gap_at = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, nw);
    for (int i = 0; i < nw; i++) begin
      if (i == gap_at) put_str("::");
      else if (i > 0) txt_buf.push_back(CH_COLON);
      put_hex_word();
    end
    if (gap_at == nw) put_str("::");
    else if ($urandom_range(0, 19) == 0) txt_buf.push_back(CH_COLON);
    maybe_prefix(140);
  endtask

  // Eight full words: 39 characters, and with a prefix right around the
  // length limit.
  task gen_wide_v6();
    for (int i = 0; i < 8; i++) begin
      if (i > 0) txt_buf.push_back(CH_COLON);
      repeat (4) put_hex_digit($urandom_range(0, 15));
    end
    case ($urandom_range(0, 4))
      1: put_str($sformatf("/%0d", $urandom_range(0, 9)));
      2: put_str($sformatf("/%0d", $urandom_range(10, 99)));
      3: put_str($sformatf("/%0d", $urandom_range(100, 199)));
      4: put_str($sformatf("/0%0d", $urandom_range(100, 128)));
      default: ;
    endcase
  endtask

  task gen_noise();
    repeat ($urandom_range(1, 50)) begin
      if ($urandom_range(0, 1)) txt_buf.push_back(pick_char());
      else txt_buf.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // Break an otherwise well-formed string: replace, insert or drop a character.
  task mutate();
    int pos;
    repeat ($urandom_range(1, 2)) begin
      pos = $urandom_range(0, txt_buf.size());
      case ($urandom_range(0, 2))
        0: if (pos < txt_buf.size()) txt_buf[pos] = pick_char();
        1: txt_buf.insert(pos, pick_char());
        default: if (pos < txt_buf.size()) txt_buf.delete(pos);
      endcase
    end
  endtask

  task commit_text(input bit drain, input bit no_gap);
    char_item_t it;
    if (txt_buf.size() == 0) txt_buf.push_back(CH_ZERO);
    foreach (txt_buf[i]) begin
      it.code  = txt_buf[i];
      it.fin   = (i == txt_buf.size() - 1);
      it.gap   = no_gap ? 0 : $urandom_range(0, 6);
      it.drain = drain && (i == 0);
      chars_to_send.push_back(it);
    end
    txt_buf.delete();
  endtask

  task log_fault(input string msg);
    if (fault_count < 10) $display("%0t ns: %s", $time, msg);
    fault_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sample both handshakes at the rising edge. Check the popped result first,
  // then feed an accepted character to the predictor; a result never leaves
  // in the cycle its last character goes in, so the order is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    iatp_result_t due;
    iatp_result_t fresh;
    bit           got;
    if (rst) begin
      char_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (parsed_due.size() == 0) begin
          log_fault("result transaction with nothing expected");
        end else begin
          due = parsed_due.pop_front();
          if (valid_res !== due.valid_res || is_v6 !== due.is_v6 ||
              address_high !== due.address_high || address_low !== due.address_low ||
              prefix_len !== due.prefix_len) begin
            log_fault($sformatf({"result mismatch: expected valid=%0b v6=%0b %h_%h /%0d, ",
                                 "got valid=%0b v6=%0b %h_%h /%0d"},
                                due.valid_res, due.is_v6, due.address_high,
                                due.address_low, due.prefix_len, valid_res, is_v6,
                                address_high, address_low, prefix_len));
          end
        end
        results_seen <= results_seen + 1;
      end
      if (push && !full) begin
        parse_char(ch, last, got, fresh);
        if (got) parsed_due.push_back(fresh);
      end
      char_taken <= push && !full;
      res_taken <= pop && !empty;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: drive at the falling edge. Drop the character just taken, count
  // down the next one's gap, and hold a drain-marked character until all
  // earlier results are in. Push is assigned once per edge so a back-to-back
  // transaction keeps it high.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      ch <= 8'd0;
      last <= 1'b0;
    end else begin
      if (char_taken) begin
        void'(chars_to_send.pop_front());
        on_bus = 1'b0;
        gap_armed = 1'b0;
      end
      if (!on_bus && chars_to_send.size() != 0) begin
        if (!gap_armed) begin
          gap_left = chars_to_send[0].gap;
          gap_armed = 1'b1;
        end
        if (chars_to_send[0].drain && parsed_due.size() != 0) begin
          // hold: wait for the block to drain
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          on_bus = 1'b1;
        end
      end
      push <= on_bus;
      if (on_bus) begin
        ch <= chars_to_send[0].code;
        last <= chars_to_send[0].fin;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall at random after each popped result. At two points hold
  // off for a long stretch so both internal queues back up and full rises;
  // over one band of results, pop without any stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_taken) begin
        if (results_seen == 40 || results_seen == 100) stall_left = LONG_HOLD;
        else if (results_seen >= 70 && results_seen < 85) stall_left = 0;
        else stall_left = $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      pop <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Build all stimulus at time zero, release reset, then wait for the queues
  // to empty and let the pipeline settle before the verdict.
  // ---------------------------------------------------------------------------
  initial begin
    string directed [] = '{
      "1.2.3.4", "0.0.0.0/0", "255.255.255.255/32", "256.0.0.1", "1.2.3.4/33",
      "1.2.3", "1..2.3", "::", "::1", "1::", "1:", ":1", ":::", "1::2::3",
      "1:2:3:4:5:6:7:8:9", "FFFF:ffff:aBcD:0:1:2:3:4/128", "12345::1", "/64",
      "::/129", "a", "/", "1.2.3.4/", "1.2.3.4//8", "1.2.3.4/9999",
      "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff/128",
      "ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff/0128"
    };
    int rnd_chars;
    int str_idx;
    int before_len;
    clear_parse();

    // directed: extremes, both families, every rejection path, length limits
    foreach (directed[i]) begin
      put_str(directed[i]);
      commit_text(1'b0, 1'b0);
    end
    put_str("1.2.3.");
    txt_buf.push_back(8'hff);
    commit_text(1'b0, 1'b0);

    // random: mostly well-formed text with random content, the rest broken or noise
    rnd_chars = 0;
    str_idx = 0;
    while (rnd_chars < RANDOM_CHARS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gen_quad_text();
        3, 4, 5: gen_v6_text();
        6: gen_wide_v6();
        7: gen_noise();
        default: if ($urandom_range(0, 1)) gen_quad_text(); else gen_v6_text();
      endcase
      if ($urandom_range(0, 3) == 0) mutate();
      before_len = chars_to_send.size();
      // drain before the random part and once midway; no gaps over one band
      commit_text(str_idx == 0 || str_idx == 60, str_idx >= 40 && str_idx < 55);
      rnd_chars += chars_to_send.size() - before_len;
      str_idx++;
    end

    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (chars_to_send.size() == 0 && parsed_due.size() == 0);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_ip_address_text_parser: clean");
    end else begin
      $display("tb_ip_address_text_parser: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run including both long hold-offs.
  initial begin
    #4_800_000;
    $display("tb_ip_address_text_parser: errors");
    $finish;
  end

endmodule
`default_nettype wire
